// ===== hdl/infix_to_prefix_converter_macros.svh =====
// Assertion macros shared by the converter's RTL.
// Each one checks a single implication on the rising clock edge.
// The check is switched off while reset is high.
`ifndef INFIX_TO_PREFIX_CONVERTER_MACROS_SVH
`define INFIX_TO_PREFIX_CONVERTER_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define IPC_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("infix_to_prefix_converter: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define IPC_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("infix_to_prefix_converter: next-cycle check failed");

`else

`define IPC_ASSERT_NOW(name, clk, rst, ante, cons)
`define IPC_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/ipc_pkg.sv =====
`timescale 1ns / 1ps

package ipc_pkg;

  // Default capacity of the character, stack and result buffers.
  localparam int MAX_LEN_DEF = 64;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  // Source of a character written into the result buffer.
  localparam logic [1:0] SRC_CBUF = 2'd0;
  localparam logic [1:0] SRC_CUR  = 2'd1;
  localparam logic [1:0] SRC_TOP  = 2'd2;

  typedef struct packed {
    logic       load_char;
    logic       scan_init;
    logic       char_rd;
    logic       latch_cur;
    logic       push;
    logic       push_cur;
    logic       pop;
    logic       emit;
    logic [1:0] emit_src;
    logic       out_rd;
    logic       out_load;
    logic       out_empty;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic i_zero;
    logic sp_zero;
    logic rc_zero;
    logic dec_open;
    logic dec_close;
    logic dec_op;
    logic top_close;
    logic top_gt;
  } sts_t;

  // Operator precedence; zero for anything that is not an operator.
  function automatic logic [1:0] prec(input logic [7:0] c);
    logic [1:0] p;
    p = 2'd0;
    if (c == CH_PLUS || c == CH_MINUS) begin
      p = 2'd1;
    end else if (c == CH_STAR || c == CH_SLASH) begin
      p = 2'd2;
    end
    return p;
  endfunction

endpackage

// ===== hdl/infix_to_prefix_converter.sv =====
`timescale 1ns / 1ps
// Channel   Handshake              Word ports
// input     start && !busy         in_char, in_last
// result    strobe (one cycle)     out_char, out_valid, out_last, out_truncated
//
// Each input word is stored in the cycle it is accepted. The word flagged by
// in_last starts a conversion: a setup step, a right-to-left scan of the stored
// characters that walks the operator stack where needed, then an output pass
// over the result words; every buffer has a registered read. busy falls in the
// cycle that shows the last result word. rst is synchronous and clears all control
// state; buffer contents are kept. The receiver cannot stall the results.

`include "infix_to_prefix_converter_macros.svh"

module infix_to_prefix_converter #(
  parameter int MAX_LEN = ipc_pkg::MAX_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_char,
  input  logic       in_last,
  output logic       strobe,
  output logic [7:0] out_char,
  output logic       out_valid,
  output logic       out_last,
  output logic       out_truncated
);

  // The controller sequences the right-to-left scan and the output pass;
  // the datapath owns the three buffers, their pointers and the result word.
  ipc_pkg::cmd_t cmd;
  ipc_pkg::sts_t sts;

  ipc_controller u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .in_last (in_last),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  ipc_datapath #(.MAX_LEN(MAX_LEN)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .in_char       (in_char),
    .strobe        (strobe),
    .out_char      (out_char),
    .out_valid     (out_valid),
    .out_last      (out_last),
    .out_truncated (out_truncated)
  );

  // A final word always starts a conversion, so the block must go busy.
  `IPC_ASSERT_NEXT(a_last_goes_busy, clk, rst, start && !busy && in_last, busy)
  // An empty expression yields exactly one word, and it closes the output.
  `IPC_ASSERT_NOW(a_empty_is_last, clk, rst, strobe && !out_valid, out_last)
  // Nothing follows the closing word of an expression.
  `IPC_ASSERT_NEXT(a_last_then_quiet, clk, rst, strobe && out_last, !strobe)
  // While more words are due, the block must still be busy.
  `IPC_ASSERT_NOW(a_more_is_busy, clk, rst, strobe && !out_last, busy)

endmodule

// ===== hdl/ipc_ram.sv =====
`timescale 1ns / 1ps

module ipc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/ipc_datapath.sv =====
`timescale 1ns / 1ps

module ipc_datapath #(
  parameter int MAX_LEN = ipc_pkg::MAX_LEN_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  ipc_pkg::cmd_t cmd,
  output ipc_pkg::sts_t sts,
  input  logic [7:0]    in_char,
  output logic          strobe,
  output logic [7:0]    out_char,
  output logic          out_valid,
  output logic          out_last,
  output logic          out_truncated
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] i;
  logic [CW-1:0] sp;
  logic [CW-1:0] rc;
  logic          dropped;
  logic [7:0]    cur;

  logic [CW-1:0] i_m1;
  logic [CW-1:0] sp_m1;
  logic [CW-1:0] rc_m1;
  logic          full;
  logic [7:0]    cb_rdata;
  logic [7:0]    st_rdata;
  logic [7:0]    rb_rdata;
  logic [7:0]    st_wdata;
  logic [7:0]    rb_wdata;

  assign i_m1  = i - CW'(1);
  assign sp_m1 = sp - CW'(1);
  assign rc_m1 = rc - CW'(1);
  assign full  = (count == CW'(MAX_LEN));

  assign st_wdata = cmd.push_cur ? cur : cb_rdata;

  always_comb begin
    case (cmd.emit_src)
      ipc_pkg::SRC_CBUF: rb_wdata = cb_rdata;
      ipc_pkg::SRC_CUR:  rb_wdata = cur;
      ipc_pkg::SRC_TOP:  rb_wdata = st_rdata;
      default:           rb_wdata = cb_rdata;
    endcase
  end

  ipc_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_char_buf (
    .clk   (clk),
    .we    (cmd.load_char && !full),
    .waddr (count[AW-1:0]),
    .wdata (in_char),
    .raddr (i_m1[AW-1:0]),
    .rdata (cb_rdata)
  );

  ipc_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_op_stack (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (sp[AW-1:0]),
    .wdata (st_wdata),
    .raddr (sp_m1[AW-1:0]),
    .rdata (st_rdata)
  );

  ipc_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_result_buf (
    .clk   (clk),
    .we    (cmd.emit),
    .waddr (rc[AW-1:0]),
    .wdata (rb_wdata),
    .raddr (rc_m1[AW-1:0]),
    .rdata (rb_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
      i       <= '0;
      sp      <= '0;
      rc      <= '0;
      strobe  <= 1'b0;
    end else begin
      if (cmd.finish) begin
        count   <= '0;
        dropped <= 1'b0;
      end else if (cmd.load_char) begin
        if (full) begin
          dropped <= 1'b1;
        end else begin
          count <= count + CW'(1);
        end
      end

      if (cmd.scan_init) begin
        i <= count;
      end else if (cmd.char_rd) begin
        i <= i_m1;
      end

      if (cmd.scan_init) begin
        sp <= '0;
      end else if (cmd.push) begin
        sp <= sp + CW'(1);
      end else if (cmd.pop) begin
        sp <= sp_m1;
      end

      if (cmd.scan_init) begin
        rc <= '0;
      end else if (cmd.emit) begin
        rc <= rc + CW'(1);
      end else if (cmd.out_rd) begin
        rc <= rc_m1;
      end

      strobe <= cmd.out_load || cmd.out_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_cur) begin
      cur <= cb_rdata;
    end
    if (cmd.out_load || cmd.out_empty) begin
      out_char      <= cmd.out_empty ? 8'd0 : rb_rdata;
      out_valid     <= !cmd.out_empty;
      out_last      <= cmd.out_empty || (rc == '0);
      out_truncated <= dropped;
    end
  end

  always_comb begin
    sts.i_zero    = (i == '0);
    sts.sp_zero   = (sp == '0);
    sts.rc_zero   = (rc == '0);
    sts.dec_open  = (cb_rdata == ipc_pkg::CH_OPEN);
    sts.dec_close = (cb_rdata == ipc_pkg::CH_CLOSE);
    sts.dec_op    = (ipc_pkg::prec(cb_rdata) != 2'd0);
    sts.top_close = (st_rdata == ipc_pkg::CH_CLOSE);
    sts.top_gt    = (ipc_pkg::prec(st_rdata) > ipc_pkg::prec(cur));
  end

endmodule

// ===== hdl/ipc_controller.sv =====
`timescale 1ns / 1ps

module ipc_controller (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          in_last,
  input  ipc_pkg::sts_t sts,
  output ipc_pkg::cmd_t cmd,
  output logic          busy
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INIT     = 3'd1;
  localparam logic [2:0] S_RD_CHAR  = 3'd2;
  localparam logic [2:0] S_DECODE   = 3'd3;
  localparam logic [2:0] S_TOP_RD   = 3'd4;
  localparam logic [2:0] S_TOP_CHK  = 3'd5;
  localparam logic [2:0] S_OUT_RD   = 3'd6;
  localparam logic [2:0] S_OUT_EMIT = 3'd7;

  // What the stack walk is doing on behalf of the current character.
  localparam logic [1:0] M_PAREN = 2'd0;
  localparam logic [1:0] M_OP    = 2'd1;
  localparam logic [1:0] M_FLUSH = 2'd2;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] mode;
  logic [1:0] mode_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode  <= M_FLUSH;
    end else begin
      state <= state_next;
      mode  <= mode_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    mode_next  = mode;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load_char = 1'b1;
          if (in_last) begin
            state_next = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd.scan_init = 1'b1;
        state_next    = S_RD_CHAR;
      end
      S_RD_CHAR: begin
        if (sts.i_zero) begin
          mode_next  = M_FLUSH;
          state_next = S_TOP_RD;
        end else begin
          cmd.char_rd = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.latch_cur = 1'b1;
        if (sts.dec_close) begin
          cmd.push   = 1'b1;
          state_next = S_RD_CHAR;
        end else if (sts.dec_open) begin
          mode_next  = M_PAREN;
          state_next = S_TOP_RD;
        end else if (sts.dec_op) begin
          mode_next  = M_OP;
          state_next = S_TOP_RD;
        end else begin
          cmd.emit     = 1'b1;
          cmd.emit_src = ipc_pkg::SRC_CBUF;
          state_next   = S_RD_CHAR;
        end
      end
      S_TOP_RD: begin
        if (sts.sp_zero) begin
          case (mode)
            M_PAREN: begin
              state_next = S_RD_CHAR;
            end
            M_OP: begin
              cmd.push     = 1'b1;
              cmd.push_cur = 1'b1;
              state_next   = S_RD_CHAR;
            end
            default: begin
              if (sts.rc_zero) begin
                cmd.out_empty = 1'b1;
                cmd.finish    = 1'b1;
                state_next    = S_IDLE;
              end else begin
                state_next = S_OUT_RD;
              end
            end
          endcase
        end else begin
          // The stack top is read every cycle; it is valid in the next state.
          state_next = S_TOP_CHK;
        end
      end
      S_TOP_CHK: begin
        case (mode)
          M_PAREN: begin
            cmd.pop = 1'b1;
            if (sts.top_close) begin
              state_next = S_RD_CHAR;
            end else begin
              cmd.emit     = 1'b1;
              cmd.emit_src = ipc_pkg::SRC_TOP;
              state_next   = S_TOP_RD;
            end
          end
          M_OP: begin
            if (sts.top_gt) begin
              cmd.pop      = 1'b1;
              cmd.emit     = 1'b1;
              cmd.emit_src = ipc_pkg::SRC_TOP;
              state_next   = S_TOP_RD;
            end else begin
              cmd.push     = 1'b1;
              cmd.push_cur = 1'b1;
              state_next   = S_RD_CHAR;
            end
          end
          default: begin
            cmd.pop      = 1'b1;
            cmd.emit     = 1'b1;
            cmd.emit_src = ipc_pkg::SRC_TOP;
            state_next   = S_TOP_RD;
          end
        endcase
      end
      S_OUT_RD: begin
        cmd.out_rd = 1'b1;
        state_next = S_OUT_EMIT;
      end
      S_OUT_EMIT: begin
        cmd.out_load = 1'b1;
        if (sts.rc_zero) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_OUT_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the infix to prefix converter.
//
// A driver feeds infix characters, one word per start/busy handshake, from a
// queue that the stimulus block fills up front. Each queued word carries its
// own idle percentage, so the sender's idling follows the phase in which the
// word was generated. When a word is accepted, the driver also hands it to a
// predictor that mirrors the converter: it stores the characters, and on the
// word flagged as last it scans them right to left with an operator stack and
// queues the prefix words that the block must produce.
//
// The monitor checks every strobed result word against the oldest queued
// prediction, one field at a time. The receiver here cannot hold results
// off, so only the sender side idles.
module testbench;

  localparam int MAX_LEN = ipc_pkg::MAX_LEN_DEF;

  // One infix character waiting to be sent, with the chance (in percent) that
  // the sender idles in any cycle before it is offered.
  typedef struct {
    logic [7:0] ch;
    logic       last;
    int         gap_pct;
  } infix_word_t;

  // One predicted prefix result word.
  typedef struct packed {
    logic [7:0] ch;
    logic       valid;
    logic       last;
    logic       trunc;
  } prefix_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [7:0] in_char = 8'h00;
  logic       in_last = 1'b0;
  logic       busy;
  logic       strobe;
  logic [7:0] out_char;
  logic       out_valid;
  logic       out_last;
  logic       out_truncated;

  infix_word_t  pending_words[$];
  prefix_word_t expected_prefix[$];
  logic [7:0]   expr_buf[$];

  // Predictor state: the characters stored for the expression in progress.
  logic [7:0] infix_chars[MAX_LEN];
  int         infix_len = 0;
  logic       chars_dropped = 1'b0;

  int error_count = 0;
  int words_accepted = 0;
  int exprs_converted = 0;
  int truncated_exprs = 0;
  int empty_results = 0;
  int results_checked = 0;

  infix_to_prefix_converter #(.MAX_LEN(MAX_LEN)) DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .in_char      (in_char),
    .in_last      (in_last),
    .strobe       (strobe),
    .out_char     (out_char),
    .out_valid    (out_valid),
    .out_last     (out_last),
    .out_truncated(out_truncated)
  );

  always #2 clk = ~clk;

  // Binding strength of an operator; zero means the character is an operand
  // or a parenthesis.
  function automatic int op_rank(input logic [7:0] c);
    if (c == ipc_pkg::CH_PLUS || c == ipc_pkg::CH_MINUS) begin
      return 1;
    end
    if (c == ipc_pkg::CH_STAR || c == ipc_pkg::CH_SLASH) begin
      return 2;
    end
    return 0;
  endfunction

  function automatic bit is_special(input logic [7:0] c);
    return op_rank(c) != 0 || c == ipc_pkg::CH_OPEN || c == ipc_pkg::CH_CLOSE;
  endfunction

  // Takes one accepted word. Characters past the buffer capacity are dropped
  // and remembered. On the last word the stored text is converted and every
  // resulting prefix word is queued, in output order.
  task automatic absorb_char(input logic [7:0] c, input logic last);
    logic [7:0]   ops[MAX_LEN];
    logic [7:0]   rev[MAX_LEN];
    logic [7:0]   ch;
    int           sp;
    int           rc;
    int           i;
    prefix_word_t w;
    if (infix_len < MAX_LEN) begin
      infix_chars[infix_len] = c;
      infix_len++;
    end else begin
      chars_dropped = 1'b1;
    end
    if (last) begin
      sp = 0;
      rc = 0;
      // Every character is pushed or emitted at most once, so neither the
      // stack nor the reversed output can outgrow the stored length.
      for (i = infix_len - 1; i >= 0; i--) begin
        ch = infix_chars[i];
        if (ch == ipc_pkg::CH_CLOSE) begin
          ops[sp] = ch;
          sp++;
        end else if (ch == ipc_pkg::CH_OPEN) begin
          // Unwind to the matching close. With no close on the stack the
          // whole stack goes out and the open is simply dropped.
          while (sp > 0 && ops[sp - 1] != ipc_pkg::CH_CLOSE) begin
            sp--;
            rev[rc] = ops[sp];
            rc++;
          end
          if (sp > 0) begin
            sp--;
          end
        end else if (op_rank(ch) != 0) begin
          // Only strictly stronger operators leave, which keeps equal
          // precedence left associative. A close has rank zero and stays.
          while (sp > 0 && op_rank(ops[sp - 1]) > op_rank(ch)) begin
            sp--;
            rev[rc] = ops[sp];
            rc++;
          end
          ops[sp] = ch;
          sp++;
        end else begin
          rev[rc] = ch;
          rc++;
        end
      end
      // Whatever is left, an unmatched close included, goes out last.
      while (sp > 0) begin
        sp--;
        rev[rc] = ops[sp];
        rc++;
      end
      if (rc == 0) begin
        w = '{ch: 8'h00, valid: 1'b0, last: 1'b1, trunc: chars_dropped};
        expected_prefix.push_back(w);
        empty_results++;
      end else begin
        for (i = 0; i < rc; i++) begin
          w = '{ch: rev[rc - 1 - i], valid: 1'b1, last: (i == rc - 1),
                trunc: chars_dropped};
          expected_prefix.push_back(w);
        end
      end
      if (chars_dropped) begin
        truncated_exprs++;
      end
      exprs_converted++;
      infix_len = 0;
      chars_dropped = 1'b0;
    end
  endtask

  // Driver. A word is taken at the edge where start is high and busy is low.
  // While the block is busy the offered word simply stays on the ports;
  // otherwise the next word is offered unless the sender idles this cycle.
  // Each branch that offers or idles makes exactly one assignment to start.
  always @(posedge clk) begin : drive_words
    infix_word_t head;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        absorb_char(in_char, in_last);
        words_accepted++;
      end
      if (!start || !busy) begin
        if (pending_words.size() != 0 &&
            $urandom_range(0, 99) >= pending_words[0].gap_pct) begin
          head = pending_words.pop_front();
          start   <= 1'b1;
          in_char <= head.ch;
          in_last <= head.last;
        end else begin
          // Idle cycle: scramble the payload so a stale word is not reused.
          start   <= 1'b0;
          in_char <= 8'($urandom);
          in_last <= 1'($urandom);
        end
      end
    end
  end

  // Monitor. A strobed word is accepted at the edge that ends its cycle.
  always @(posedge clk) begin : check_results
    prefix_word_t want;
    if (!rst && strobe) begin
      if (expected_prefix.size() == 0) begin
        $display("%0t: result word with nothing expected: char %h valid %b last %b trunc %b",
                 $time, out_char, out_valid, out_last, out_truncated);
        error_count++;
      end else begin
        want = expected_prefix.pop_front();
        results_checked++;
        if (out_char !== want.ch) begin
          $display("%0t: out_char expected %h actual %h", $time, want.ch, out_char);
          error_count++;
        end
        if (out_valid !== want.valid) begin
          $display("%0t: out_valid expected %b actual %b", $time, want.valid, out_valid);
          error_count++;
        end
        if (out_last !== want.last) begin
          $display("%0t: out_last expected %b actual %b", $time, want.last, out_last);
          error_count++;
        end
        if (out_truncated !== want.trunc) begin
          $display("%0t: out_truncated expected %b actual %b",
                   $time, want.trunc, out_truncated);
          error_count++;
        end
      end
    end
  end

  // Stimulus helpers. An expression is built up in expr_buf and then moved
  // to the driver's queue with the last flag on its final character.
  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      expr_buf.push_back(s[i]);
    end
  endtask

  task automatic commit_expression(input int gap_pct);
    infix_word_t w;
    int          i;
    for (i = 0; i < expr_buf.size(); i++) begin
      w = '{ch: expr_buf[i], last: (i == expr_buf.size() - 1), gap_pct: gap_pct};
      pending_words.push_back(w);
    end
    expr_buf.delete();
  endtask

  function automatic logic [7:0] operand_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (is_special(c)) begin
      c = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  function automatic logic [7:0] operator_char();
    case ($urandom_range(0, 3))
      0: return ipc_pkg::CH_PLUS;
      1: return ipc_pkg::CH_MINUS;
      2: return ipc_pkg::CH_STAR;
      default: return ipc_pkg::CH_SLASH;
    endcase
  endfunction

  // Operands joined by operators, with random balanced grouping.
  task automatic build_wellformed(input int max_operands);
    int n;
    int k;
    int depth;
    depth = 0;
    n = $urandom_range(1, max_operands);
    for (k = 0; k < n; k++) begin
      if (k > 0) begin
        expr_buf.push_back(operator_char());
      end
      while (depth < 4 && $urandom_range(0, 3) == 0) begin
        expr_buf.push_back(ipc_pkg::CH_OPEN);
        depth++;
      end
      expr_buf.push_back(operand_char());
      while (depth > 0 && $urandom_range(0, 2) == 0) begin
        expr_buf.push_back(ipc_pkg::CH_CLOSE);
        depth--;
      end
    end
    while (depth > 0) begin
      expr_buf.push_back(ipc_pkg::CH_CLOSE);
      depth--;
    end
  endtask

  // Broken text: operators and parentheses in any order, mixed with operands.
  task automatic build_broken(input int len);
    int k;
    for (k = 0; k < len; k++) begin
      case ($urandom_range(0, 3))
        0: expr_buf.push_back(ipc_pkg::CH_OPEN);
        1: expr_buf.push_back(ipc_pkg::CH_CLOSE);
        2: expr_buf.push_back(operator_char());
        default: expr_buf.push_back(operand_char());
      endcase
    end
  endtask

  task automatic build_noise(input int len);
    int k;
    for (k = 0; k < len; k++) begin
      expr_buf.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin : stimulus
    int phase_gap[4];
    int random_words;
    int kind;
    phase_gap = '{0, 59, 0, 15};

    // Directed expressions, sent back to back.
    add_text("a+b*c");        // mixed precedence
    commit_expression(0);
    add_text("a-b-c");        // equal precedence must stay left associative
    commit_expression(0);
    add_text("(a-b)/c");      // grouping that is dropped from the output
    commit_expression(0);
    add_text(")x");           // close paren with no open to its left
    commit_expression(0);
    add_text("(y");           // open paren with no close to its right
    commit_expression(0);
    add_text("()");           // nothing left to emit
    commit_expression(0);
    expr_buf.push_back(8'h00);  // the zero byte is an ordinary operand
    expr_buf.push_back(8'hFF);
    commit_expression(0);

    // Random expressions, in four idling phases.
    random_words = 0;
    while (random_words < 60) begin
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        build_wellformed(6);
      end else if (kind < 85) begin
        build_broken($urandom_range(1, 8));
      end else begin
        build_noise($urandom_range(1, 8));
      end
      random_words += expr_buf.size();
      commit_expression(phase_gap[(random_words * 4 / 61) % 4]);
    end

    // Buffer boundary: overflow with the last character itself dropped.
    build_broken(MAX_LEN + 1);
    commit_expression(15);

    // Release reset, then let the driver drain the queue.
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    while (pending_words.size() != 0 || start) begin
      @(posedge clk);
    end
    while (expected_prefix.size() != 0) begin
      @(posedge clk);
    end
    // Keep running to catch any stray result word.
    repeat (50) @(posedge clk);

    $display("Sent %0d words in %0d expressions; checked %0d result words.",
             words_accepted, exprs_converted, results_checked);
    $display("Covered %0d truncated expressions and %0d empty outputs.",
             truncated_exprs, empty_results);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin : watchdog
    #400000;
    $display("Timed out with %0d words queued and %0d results outstanding.",
             pending_words.size(), expected_prefix.size());
    $display("testbench: errors");
    $finish;
  end

endmodule
